>>> rtl/core/tick_task_release_scheduler_defines.svh
// Assertion macros for the tick task release scheduler.
`ifndef TICK_TASK_RELEASE_SCHEDULER_DEFINES_SVH
`define TICK_TASK_RELEASE_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked after reset has been released.
`define TTRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, also while reset is applied.
`define TTRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTRS_ASSERT(lbl, clk, rstn, prop, msg)
`define TTRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/core/ttrs_pkg.sv
// Shared types, constants and microcode table of the tick task release scheduler.
package ttrs_pkg;

  localparam int STEP_W    = 3;
  localparam int IDX_OUT_W = 3;
  localparam int DATA_W    = 16;
  localparam int LEVEL_W   = 4;
  localparam int RUN_CAP   = 8;
  localparam int CAP_W     = 3;

  localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
  localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ADD      = 3'd2;
  localparam logic [STEP_W-1:0] STEP_UPDATE   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_RELEASE  = 3'd4;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_ADD,
    ACT_UPDATE,
    ACT_RELEASE
  } act_e;

  typedef enum logic [1:0] {
    COND_IN_VALID,
    COND_CMD_ADD,
    COND_PTR_LAST,
    COND_DONE
  } cond_e;

  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [STEP_W-1:0] jump_true;
    logic [STEP_W-1:0] jump_false;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic cmd_add;
    logic ptr_last;
    logic done;
  } flags_t;

  // One control word per step: action, branch condition and both targets.
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      STEP_IDLE:     w = '{act: ACT_ACCEPT, cond: COND_IN_VALID,
                           jump_true: STEP_DISPATCH, jump_false: STEP_IDLE};
      STEP_DISPATCH: w = '{act: ACT_NONE, cond: COND_CMD_ADD,
                           jump_true: STEP_ADD, jump_false: STEP_UPDATE};
      STEP_ADD:      w = '{act: ACT_ADD, cond: COND_DONE,
                           jump_true: STEP_IDLE, jump_false: STEP_ADD};
      STEP_UPDATE:   w = '{act: ACT_UPDATE, cond: COND_PTR_LAST,
                           jump_true: STEP_RELEASE, jump_false: STEP_UPDATE};
      STEP_RELEASE:  w = '{act: ACT_RELEASE, cond: COND_DONE,
                           jump_true: STEP_IDLE, jump_false: STEP_RELEASE};
      default:       w = '{act: ACT_NONE, cond: COND_IN_VALID,
                           jump_true: STEP_IDLE, jump_false: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/ttrs_sequencer.sv
// Step counter and microcode table lookup with conditional branching.
module ttrs_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ttrs_pkg::flags_t flags_i,
  output ttrs_pkg::uword_t uword_o
);

  logic [ttrs_pkg::STEP_W-1:0] step_q, step_d;
  logic                        taken;

  assign uword_o = ttrs_pkg::ucode_rom(step_q);

  always_comb begin
    case (uword_o.cond)
      ttrs_pkg::COND_IN_VALID: taken = flags_i.in_valid;
      ttrs_pkg::COND_CMD_ADD:  taken = flags_i.cmd_add;
      ttrs_pkg::COND_PTR_LAST: taken = flags_i.ptr_last;
      ttrs_pkg::COND_DONE:     taken = flags_i.done;
      default:                 taken = 1'b0;
    endcase
    step_d = taken ? uword_o.jump_true : uword_o.jump_false;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ttrs_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> rtl/core/tick_task_release_scheduler.sv
// Top level of the tick task release scheduler: microcoded slot walker and output register.
// Add request: accept, then dispatch, then a walk over the slots to a free slot.
// Tick request: accept, dispatch, a countdown update of every slot (one slot per cycle), then
// a release scan over the slots; each slot visit repeats the same step of the sequencer.
// One request is in work at a time; the last result may wait in the output register while
// the next request is taken. Reset clears valid and pending bits and empties the output.
`include "tick_task_release_scheduler_defines.svh"

module tick_task_release_scheduler #(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [15:0] start_delay_i,
  input  logic [15:0] task_period_i,
  input  logic [3:0]  running_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  task_index_o,
  output logic        table_full_o,
  output logic        last_of_run_o
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CMP_W = (IDX_W > ttrs_pkg::LEVEL_W) ? IDX_W : ttrs_pkg::LEVEL_W;

  // Control word of the current step and the flags that steer its branch.
  ttrs_pkg::uword_t uword;
  ttrs_pkg::flags_t flags;

  // Captured request.
  logic                          cmd_q;
  logic [ttrs_pkg::DATA_W-1:0]   delay_q;
  logic [ttrs_pkg::DATA_W-1:0]   period_q;
  logic [ttrs_pkg::LEVEL_W-1:0]  level_q;
  logic                          in_accept;

  // Slot table. Countdown and period are only read for valid slots.
  logic [TASK_SLOTS-1:0]         valid_q, valid_d;
  logic [TASK_SLOTS-1:0]         pend_q, pend_d;
  logic [ttrs_pkg::DATA_W-1:0]   cd_q  [TASK_SLOTS];
  logic [ttrs_pkg::DATA_W-1:0]   per_q [TASK_SLOTS];
  logic [ttrs_pkg::DATA_W-1:0]   cd_rd, per_rd, cd_wdata;
  logic                          cd_we, per_we;

  // Walk pointer and count of releases in this tick.
  logic [IDX_W-1:0]              ptr_q, ptr_d;
  logic [ttrs_pkg::CAP_W-1:0]    n_q, n_d;
  logic                          ptr_last;
  logic                          out_free;
  logic                          step_done;

  // Eligible slots for release and those above the pointer.
  logic [TASK_SLOTS-1:0]         elig;
  logic [TASK_SLOTS-1:0]         elig_above;
  logic                          none_above;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic [ttrs_pkg::IDX_OUT_W-1:0] out_idx_q, out_idx_d;
  logic                          out_full_q, out_full_d;
  logic                          out_last_q, out_last_d;

  ttrs_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uword)
  );

  // A request is taken only in the idle step of the program.
  assign in_ready_o = (uword.act == ttrs_pkg::ACT_ACCEPT);
  assign in_accept  = in_valid_i && in_ready_o;

  assign ptr_last = (ptr_q == IDX_W'(TASK_SLOTS - 1));
  assign out_free = !out_valid_q || out_ready_i;
  assign cd_rd    = cd_q[ptr_q];
  assign per_rd   = per_q[ptr_q];

  assign flags.in_valid = in_valid_i;
  assign flags.cmd_add  = cmd_q;
  assign flags.ptr_last = ptr_last;
  assign flags.done     = step_done;

  // A slot may be released when it is valid, pending and below the running level.
  // Levels beyond the table simply admit every slot.
  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      elig[i]       = valid_q[i] && pend_q[i] && (CMP_W'(i) < CMP_W'(level_q));
      elig_above[i] = elig[i] && (IDX_W'(i) > ptr_q);
    end
  end
  assign none_above = ~|elig_above;

  always_comb begin
    valid_d     = valid_q;
    pend_d      = pend_q;
    ptr_d       = ptr_q;
    n_d         = n_q;
    cd_we       = 1'b0;
    per_we      = 1'b0;
    cd_wdata    = cd_rd;
    step_done   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_full_d  = out_full_q;
    out_last_d  = out_last_q;
    case (uword.act)
      ttrs_pkg::ACT_ACCEPT: begin
        ptr_d = '0;
        n_d   = '0;
      end
      ttrs_pkg::ACT_ADD: begin
        if (out_free) begin
          if (!valid_q[ptr_q]) begin
            valid_d[ptr_q] = 1'b1;
            pend_d[ptr_q]  = 1'b0;
            cd_we          = 1'b1;
            cd_wdata       = delay_q;
            per_we         = 1'b1;
            out_valid_d    = 1'b1;
            out_idx_d      = ttrs_pkg::IDX_OUT_W'(ptr_q);
            out_full_d     = 1'b0;
            out_last_d     = 1'b1;
            step_done      = 1'b1;
          end else if (ptr_last) begin
            out_valid_d = 1'b1;
            out_idx_d   = '0;
            out_full_d  = 1'b1;
            out_last_d  = 1'b1;
            step_done   = 1'b1;
          end else begin
            ptr_d = ptr_q + IDX_W'(1);
          end
        end
      end
      ttrs_pkg::ACT_UPDATE: begin
        if (valid_q[ptr_q]) begin
          cd_we = 1'b1;
          if (cd_rd != '0) begin
            cd_wdata = cd_rd - ttrs_pkg::DATA_W'(1);
          end else begin
            pend_d[ptr_q] = 1'b1;
            // A one-shot task reloads zero and so stays due every tick.
            cd_wdata = (per_rd != '0) ? (per_rd - ttrs_pkg::DATA_W'(1)) : '0;
          end
        end
        ptr_d = ptr_last ? '0 : (ptr_q + IDX_W'(1));
      end
      ttrs_pkg::ACT_RELEASE: begin
        if (elig[ptr_q]) begin
          if (out_free) begin
            pend_d[ptr_q] = 1'b0;
            if (per_rd == '0) begin
              valid_d[ptr_q] = 1'b0;
            end
            out_valid_d = 1'b1;
            out_idx_d   = ttrs_pkg::IDX_OUT_W'(ptr_q);
            out_full_d  = 1'b0;
            // The run ends at the release cap or when nothing eligible remains above.
            out_last_d  = none_above || (n_q == ttrs_pkg::CAP_W'(ttrs_pkg::RUN_CAP - 1));
            n_d         = n_q + ttrs_pkg::CAP_W'(1);
            step_done   = out_last_d;
            if (!out_last_d) begin
              ptr_d = ptr_q + IDX_W'(1);
            end
          end
        end else if (ptr_last) begin
          step_done = 1'b1;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      pend_q      <= '0;
      ptr_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      pend_q      <= pend_d;
      ptr_q       <= ptr_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= command_i;
      delay_q  <= start_delay_i;
      period_q <= task_period_i;
      level_q  <= running_level_i;
    end
    if (cd_we) begin
      cd_q[ptr_q] <= cd_wdata;
    end
    if (per_we) begin
      per_q[ptr_q] <= period_q;
    end
    out_idx_q  <= out_idx_d;
    out_full_q <= out_full_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign task_index_o  = out_idx_q;
  assign table_full_o  = out_full_q;
  assign last_of_run_o = out_last_q;

  // A full-table answer is always the single, final result of its add, at slot zero.
  `TTRS_ASSERT(a_full_is_last, clk_i, rst_ni, out_valid_o && table_full_o |-> last_of_run_o && (task_index_o == '0), "table full result must be last and at slot zero")
  // Only occupied slots can be pending.
  `TTRS_ASSERT_ALWAYS(a_pend_needs_valid, clk_i, (pend_q & ~valid_q) == '0, "pending bit set on a free slot")

endmodule
